@@ hw/rtl/bq_pkg.sv @@
// Shared constants, codes and types for the cascaded biquad filter.
`timescale 1ns / 1ps

package bq_pkg;

    localparam int MAX_SECTIONS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 24;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 28;
    localparam int ACC_W     = 68;
    localparam int ADDR_W    = 3;

    localparam logic [1:0] OP_FILTER = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] COEF_X1 = 2'd0;
    localparam logic [1:0] COEF_Y1 = 2'd1;
    localparam logic [1:0] COEF_X2 = 2'd2;
    localparam logic [1:0] COEF_Y2 = 2'd3;

    localparam logic REG_COUNT = 1'b0;
    localparam logic REG_GAIN  = 1'b1;

    localparam logic signed [DATA_W-1:0] GAIN_RESET = 32'sd268435456;

    typedef struct packed {
        logic mul;
        logic neg;
        logic add;
        logic clr;
    } mac_ctrl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x1;
        logic signed [DATA_W-1:0] x2;
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W-1:0] y2;
    } hist_row_t;

endpackage

@@ hw/rtl/bq_mac.sv @@
// Shared multiply-accumulate unit: registered 32x32 product, then a wide accumulator.
`timescale 1ns / 1ps

module bq_mac (
    input  logic                                 clk,
    input  bq_pkg::mac_ctrl_t                    ctrl,
    input  logic signed [bq_pkg::DATA_W-1:0]     op_a,
    input  logic signed [bq_pkg::DATA_W-1:0]     op_b,
    input  logic signed [bq_pkg::ACC_W-1:0]      init,
    output logic signed [bq_pkg::ACC_W-1:0]      acc
);
    import bq_pkg::*;

    logic signed [2*DATA_W-1:0] prod_reg;
    logic                       neg_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    term;

    always_comb
    begin
        term = ACC_W'(prod_reg);
        if (neg_reg)
        begin
            term = -term;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            prod_reg <= op_a * op_b;
            neg_reg  <= ctrl.neg;
        end
        if (ctrl.clr)
        begin
            acc_reg <= init;
        end
        else if (ctrl.add)
        begin
            acc_reg <= acc_reg + term;
        end
    end

    assign acc = acc_reg;

endmodule

@@ hw/rtl/bq_coef_ram.sv @@
// Coefficient memory: four words per section, one write and one registered read a cycle.
`timescale 1ns / 1ps

module bq_coef_ram #(
    parameter int SEC_W = 4
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [SEC_W+1:0]                 wr_addr,
    input  logic signed [bq_pkg::DATA_W-1:0] wr_data,
    input  logic [SEC_W+1:0]                 rd_addr,
    output logic signed [bq_pkg::DATA_W-1:0] rd_data
);
    import bq_pkg::*;

    localparam int DEPTH = 4 * (1 << SEC_W);

    logic signed [DATA_W-1:0] mem [0:DEPTH-1];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/bq_hist_ram.sv @@
// Section history memory, one row of x1, x2, y1, y2 per section, with valid bits for clearing.
`timescale 1ns / 1ps

module bq_hist_ram #(
    parameter int SEC_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clr,
    input  logic              wr_en,
    input  logic [SEC_W-1:0]  wr_addr,
    input  bq_pkg::hist_row_t wr_row,
    input  logic              rd_en,
    input  logic [SEC_W-1:0]  rd_addr,
    output bq_pkg::hist_row_t rd_row
);
    import bq_pkg::*;

    localparam int DEPTH = 1 << SEC_W;

    hist_row_t        mem [0:DEPTH-1];
    hist_row_t        rd_row_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    // A row never written since reset or the last clear reads as zero history.
    assign rd_row = rd_valid_reg ? rd_row_reg : '0;

endmodule

@@ hw/rtl/cascaded_biquad_iir_filter.sv @@
// Top level: APB registers, item handshake and the section sequencer around one shared MAC.
// A filter item runs each section in use in turn on the one shared multiplier, then the
// output gain; in_ready stays low until its result is in the output register, and ST_OUT
// waits while an earlier result is still unaccepted. Write and clear items finish on acceptance.
// Reset: history reads as zero, section_count is 0, output_gain is 1.0 (Q4.28);
// coefficients are undefined until written.
`timescale 1ns / 1ps

module cascaded_biquad_iir_filter #(
    parameter int MAX_SECTIONS_BUILT = bq_pkg::MAX_SECTIONS_DEF,
    parameter int SAMPLE_BITS        = bq_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bq_pkg::ADDR_W-1:0]        paddr,
    input  logic [bq_pkg::DATA_W-1:0]        pwdata,
    output logic [bq_pkg::DATA_W-1:0]        prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       operation,
    input  logic signed [SAMPLE_BITS-1:0]    sample_in,
    input  logic [3:0]                       section_index,
    input  logic [1:0]                       coef_select,
    input  logic signed [bq_pkg::DATA_W-1:0] coef_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [SAMPLE_BITS-1:0]    sample_out,
    output logic                             saturated
);
    import bq_pkg::*;

    localparam int SEC_W = (MAX_SECTIONS_BUILT > 1) ? $clog2(MAX_SECTIONS_BUILT) : 1;
    localparam int CNT_W = (SEC_W + 1 >= 5) ? SEC_W + 1 : 5;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SECTIONS_BUILT);
    localparam logic [2:0] PH_SEC_LAST  = 3'd6;
    localparam logic [2:0] PH_GAIN_LAST = 3'd2;
    localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SECTION,
        ST_GAIN,
        ST_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [2:0]               ph_reg, ph_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [SAMPLE_BITS-1:0] y_reg, y_next;
    logic                     sat_reg, sat_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg, sample_out_next;
    logic                     saturated_reg, saturated_next;

    logic [4:0]               section_count_reg;
    logic signed [DATA_W-1:0] output_gain_reg;

    logic                     accept;
    logic                     cfg_write;
    logic [CNT_W-1:0]         cnt_ext;
    logic [CNT_W-1:0]         n_eff;

    mac_ctrl_t                mac_ctrl;
    logic signed [DATA_W-1:0] mac_a;
    logic signed [DATA_W-1:0] mac_b;
    logic signed [ACC_W-1:0]  mac_init;
    logic signed [ACC_W-1:0]  acc;

    logic                     coef_wr_en;
    logic [SEC_W+1:0]         coef_rd_addr;
    logic [1:0]               coef_sel;
    logic signed [DATA_W-1:0] coef_rd;

    logic                     hist_clr;
    logic                     hist_wr_en;
    logic                     hist_rd_en;
    hist_row_t                hist_wr_row;
    hist_row_t                hist_rd;

    logic [ACC_W-1-(FRAC_BITS+DATA_W-1):0]      sec_upper;
    logic                                       sec_fits;
    logic signed [DATA_W-1:0]                   sec_r;
    logic [ACC_W-1-(FRAC_BITS+SAMPLE_BITS-1):0] out_upper;
    logic                                       out_fits;
    logic signed [SAMPLE_BITS-1:0]              out_y;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_COUNT: prdata = DATA_W'(section_count_reg);
            REG_GAIN:  prdata = output_gain_reg;
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_count_reg <= '0;
            output_gain_reg   <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_COUNT)
            begin
                section_count_reg <= pwdata[4:0];
            end
            else
            begin
                output_gain_reg <= pwdata;
            end
        end
    end

    // Item intake
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign cnt_ext  = CNT_W'(section_count_reg);
    assign n_eff    = (cnt_ext > MAX_CNT) ? MAX_CNT : cnt_ext;

    assign coef_wr_en = accept && (operation == OP_WRITE)
                        && (CNT_W'(section_index) < MAX_CNT);
    assign hist_clr   = accept && (operation == OP_CLEAR);

    // Coefficient fetch order follows the products: x1, x2, y1, y2.
    always_comb
    begin
        case (ph_reg)
            3'd1:    coef_sel = COEF_X2;
            3'd2:    coef_sel = COEF_Y1;
            3'd3:    coef_sel = COEF_Y2;
            default: coef_sel = COEF_X1;
        endcase
    end

    assign coef_rd_addr = {k_reg[SEC_W-1:0], coef_sel};

    bq_coef_ram #(
        .SEC_W (SEC_W)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_wr_en),
        .wr_addr ({SEC_W'(section_index), coef_select}),
        .wr_data (coef_value),
        .rd_addr (coef_rd_addr),
        .rd_data (coef_rd)
    );

    assign hist_rd_en = (state_reg == ST_SECTION) && (ph_reg == 3'd0);
    assign hist_wr_en = (state_reg == ST_SECTION) && (ph_reg == PH_SEC_LAST);

    always_comb
    begin
        hist_wr_row.x1 = x_reg;
        hist_wr_row.x2 = hist_rd.x1;
        hist_wr_row.y1 = sec_r;
        hist_wr_row.y2 = hist_rd.y1;
    end

    bq_hist_ram #(
        .SEC_W (SEC_W)
    ) u_hist_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (hist_clr),
        .wr_en   (hist_wr_en),
        .wr_addr (k_reg[SEC_W-1:0]),
        .wr_row  (hist_wr_row),
        .rd_en   (hist_rd_en),
        .rd_addr (k_reg[SEC_W-1:0]),
        .rd_row  (hist_rd)
    );

    // MAC schedule. Products are registered, and enter the accumulator in the next cycle.
    always_comb
    begin
        mac_ctrl = '0;
        mac_a    = coef_rd;
        mac_b    = hist_rd.x1;
        mac_init = ROUND;
        if (state_reg == ST_SECTION)
        begin
            case (ph_reg)
                3'd0:
                begin
                    mac_ctrl.clr = 1'b1;
                    mac_init     = (ACC_W'(x_reg) <<< FRAC_BITS) + ROUND;
                end
                3'd1:
                begin
                    mac_ctrl.mul = 1'b1;
                end
                3'd2:
                begin
                    mac_ctrl.mul = 1'b1;
                    mac_ctrl.add = 1'b1;
                    mac_b        = hist_rd.x2;
                end
                3'd3:
                begin
                    mac_ctrl.mul = 1'b1;
                    mac_ctrl.neg = 1'b1;
                    mac_ctrl.add = 1'b1;
                    mac_b        = hist_rd.y1;
                end
                3'd4:
                begin
                    mac_ctrl.mul = 1'b1;
                    mac_ctrl.neg = 1'b1;
                    mac_ctrl.add = 1'b1;
                    mac_b        = hist_rd.y2;
                end
                3'd5:
                begin
                    mac_ctrl.add = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == ST_GAIN)
        begin
            mac_a = x_reg;
            mac_b = output_gain_reg;
            case (ph_reg)
                3'd0:
                begin
                    mac_ctrl.mul = 1'b1;
                    mac_ctrl.clr = 1'b1;
                end
                3'd1:
                begin
                    mac_ctrl.add = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    bq_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .init (mac_init),
        .acc  (acc)
    );

    // Rounded sum, floored by FRAC_BITS; sections saturate to 32 bits, output to SAMPLE_BITS.
    assign sec_upper = acc[ACC_W-1:FRAC_BITS+DATA_W-1];
    assign sec_fits  = (&sec_upper) || !(|sec_upper);
    assign sec_r     = sec_fits ? acc[FRAC_BITS+DATA_W-1:FRAC_BITS]
                     : (acc[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}});

    assign out_upper = acc[ACC_W-1:FRAC_BITS+SAMPLE_BITS-1];
    assign out_fits  = (&out_upper) || !(|out_upper);
    assign out_y     = out_fits ? acc[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS]
                     : (acc[ACC_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_BITS-1){1'b1}}});

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        ph_next         = ph_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        sat_next        = sat_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        saturated_next  = saturated_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_FILTER))
                begin
                    x_next   = DATA_W'(sample_in);
                    n_next   = n_eff;
                    k_next   = '0;
                    ph_next  = '0;
                    sat_next = 1'b0;
                    state_next = (n_eff == '0) ? ST_GAIN : ST_SECTION;
                end
            end
            ST_SECTION:
            begin
                if (ph_reg == PH_SEC_LAST)
                begin
                    x_next   = sec_r;
                    sat_next = sat_reg || !sec_fits;
                    k_next   = k_reg + 1'b1;
                    ph_next  = '0;
                    if (k_reg + 1'b1 == n_reg)
                    begin
                        state_next = ST_GAIN;
                    end
                end
                else
                begin
                    ph_next = ph_reg + 1'b1;
                end
            end
            ST_GAIN:
            begin
                if (ph_reg == PH_GAIN_LAST)
                begin
                    y_next     = out_y;
                    sat_next   = sat_reg || !out_fits;
                    ph_next    = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    ph_next = ph_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                // Wait until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = y_reg;
                    saturated_next  = sat_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        sat_reg        <= sat_next;
        sample_out_reg <= sample_out_next;
        saturated_reg  <= saturated_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = saturated_reg;

endmodule
